// ===== hdl/crc16pd_pkg.sv =====
`timescale 1ns / 1ps

package crc16pd_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_BUSY   = 3'd0,
        ST_ACCEPT = 3'd1,
        ST_REJECT = 3'd2,
        ST_BADCRC = 3'd3,
        ST_FLUSH  = 3'd4
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_POLY   = 2'd0,
        CFG_START  = 2'd1,
        CFG_MAXLEN = 2'd2,
        CFG_SPARE  = 2'd3
    } cfg_idx_t;

    localparam logic [15:0] POLY_RESET   = 16'hA001;
    localparam logic [15:0] START_RESET  = 16'hFFFF;
    localparam logic [7:0]  MAXLEN_RESET = 8'd62;
    localparam int          POS_W        = 9;

    typedef struct packed {
        logic [15:0] poly;
        logic [15:0] start;
        logic [7:0]  max_len;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  command;
        logic [7:0]  length;
        logic        payload_valid;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
    } result_t;

    // Reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc16pd_parser.sv =====
`timescale 1ns / 1ps

module crc16pd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 mode,
    input  logic [7:0]           data_byte,
    input  crc16pd_pkg::cfg_t    cfg,
    output crc16pd_pkg::result_t result
);

    localparam int PW = crc16pd_pkg::POS_W;

    logic [PW-1:0] frame_position_reg, frame_position_next;
    logic [15:0]   running_crc_reg, running_crc_next;
    logic [7:0]    frame_command_reg, frame_command_next;
    logic [7:0]    frame_length_reg, frame_length_next;

    logic [PW-1:0] crc_pos;
    logic [PW-1:0] pos_m2;
    logic [15:0]   crc_upd;

    assign crc_pos = PW'(2) + {1'b0, frame_length_reg};
    assign pos_m2  = frame_position_reg - PW'(2);
    assign crc_upd = crc16pd_pkg::crc_byte(running_crc_reg, data_byte, cfg.poly);

    always_comb begin
        frame_position_next   = frame_position_reg;
        running_crc_next      = running_crc_reg;
        frame_command_next    = frame_command_reg;
        frame_length_next     = frame_length_reg;
        result.status         = crc16pd_pkg::ST_BUSY;
        result.payload_valid  = 1'b0;
        result.payload_index  = 8'd0;
        result.payload_byte   = 8'd0;

        priority if (mode) begin
            frame_position_next = '0;
            running_crc_next    = cfg.start;
            result.status       = crc16pd_pkg::ST_FLUSH;
        end else if (frame_position_reg == PW'(0)) begin
            frame_command_next  = data_byte;
            running_crc_next    = crc_upd;
            frame_position_next = PW'(1);
        end else if (frame_position_reg == PW'(1)) begin
            frame_length_next   = data_byte;
            running_crc_next    = crc_upd;
            frame_position_next = PW'(2);
        end else if (frame_position_reg < crc_pos) begin
            if (frame_position_reg == PW'(2) && frame_length_reg > cfg.max_len) begin
                // oversized frame: this byte is dropped
                frame_position_next = '0;
                running_crc_next    = cfg.start;
                result.status       = crc16pd_pkg::ST_REJECT;
            end else begin
                running_crc_next     = crc_upd;
                result.payload_valid = 1'b1;
                result.payload_index = pos_m2[7:0];
                result.payload_byte  = data_byte;
                frame_position_next  = frame_position_reg + PW'(1);
            end
        end else if (frame_position_reg == crc_pos) begin
            if (data_byte != running_crc_reg[15:8]) begin
                frame_position_next = '0;
                running_crc_next    = cfg.start;
                result.status       = crc16pd_pkg::ST_BADCRC;
            end else begin
                frame_position_next = frame_position_reg + PW'(1);
            end
        end else begin
            result.status = (data_byte != running_crc_reg[7:0]) ?
                            crc16pd_pkg::ST_BADCRC : crc16pd_pkg::ST_ACCEPT;
            frame_position_next = '0;
            running_crc_next    = cfg.start;
        end

        result.command = frame_command_next;
        result.length  = frame_length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_position_reg <= '0;
            running_crc_reg    <= crc16pd_pkg::START_RESET;
            frame_command_reg  <= 8'd0;
            frame_length_reg   <= 8'd0;
        end else if (step_en) begin
            frame_position_reg <= frame_position_next;
            running_crc_reg    <= running_crc_next;
            frame_command_reg  <= frame_command_next;
            frame_length_reg   <= frame_length_next;
        end
    end

endmodule

// ===== hdl/crc16_packet_deframer_top.sv =====
`timescale 1ns / 1ps
// CRC-16 checked packet deframer.
// Input channel (s_valid/s_ready): one transaction per received byte
// (s_mode = 0, byte on s_data_byte) or an idle poll (s_mode = 1) that
// flushes any partial frame. Frames are: command, length, payload,
// CRC high byte, CRC low byte; the reflected CRC covers command, length
// and payload.
// Result channel (m_valid/m_ready): exactly one transaction per input
// transaction: status, current command and length, and the payload byte
// with its index when the byte was payload.
// Latency: a result is presented the cycle after its input is taken.
// Throughput: one byte per cycle unless stalled; the byte-wide CRC update
// and frame position compare lie between parser state and result reg.
// Stall: the result register holds a pending result while m_ready is low;
// s_ready drops only while a result is held and not being taken.
// Config channel (cfg_valid/cfg_ready): always ready; index 0 polynomial,
// 1 start value, 2 max payload length. Write only while idle.
// Reset (aresetn, sync, active low): parser at frame start, CRC at the
// default start value, registers at their defaults, no result pending.

module crc16_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_command,
    output logic [7:0]  m_length,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_index,
    output logic [7:0]  m_payload_byte,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    crc16pd_pkg::cfg_t    cfg_reg;
    crc16pd_pkg::result_t result;
    crc16pd_pkg::result_t res_reg;
    logic                 m_valid_reg;
    logic                 in_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poly    <= crc16pd_pkg::POLY_RESET;
            cfg_reg.start   <= crc16pd_pkg::START_RESET;
            cfg_reg.max_len <= crc16pd_pkg::MAXLEN_RESET;
        end else if (cfg_valid) begin
            unique case (crc16pd_pkg::cfg_idx_t'(cfg_index))
                crc16pd_pkg::CFG_POLY:   cfg_reg.poly    <= cfg_data;
                crc16pd_pkg::CFG_START:  cfg_reg.start   <= cfg_data;
                crc16pd_pkg::CFG_MAXLEN: cfg_reg.max_len <= cfg_data[7:0];
                default: ;  // unused index, write ignored
            endcase
        end
    end

    crc16pd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (in_fire),
        .mode      (s_mode),
        .data_byte (s_data_byte),
        .cfg       (cfg_reg),
        .result    (result)
    );

    // result register: loads on every accepted input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= result;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = res_reg.status;
    assign m_command       = res_reg.command;
    assign m_length        = res_reg.length;
    assign m_payload_valid = res_reg.payload_valid;
    assign m_payload_index = res_reg.payload_index;
    assign m_payload_byte  = res_reg.payload_byte;

`ifndef SYNTHESIS
    // a held result must back-pressure the input
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // every accepted input yields a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("missing result after input transaction");

    // payload bytes never carry a terminal status
    a_payload_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid |-> m_status == crc16pd_pkg::ST_BUSY)
        else $error("payload byte with non-busy status");

    // non-payload results show zero index and byte
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload_valid |-> m_payload_index == 8'd0 && m_payload_byte == 8'd0)
        else $error("stale payload fields");
`endif

endmodule
